/* rtl/rcrb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcrb_pkg
// Shared constants, types and the draw function of the random ring builder.
// ----------------------------------------------------------------------------
package rcrb_pkg;

	// table size
	localparam int MAX_ENTRIES_DEF = 1024;

	// field widths
	localparam int LEN_W     = 11;
	localparam int IDX_W     = 10;
	localparam int TDATA_W   = 16;
	localparam int DRAW_W    = 64;

	localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;
	localparam int MIN_RING = 2;

	// tuser codes on the input channel
	localparam logic ACT_BUILD  = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	// xorshift64
	localparam logic [DRAW_W-1:0] SEED_CONST = 64'h9e3779b97f4a7c15;
	localparam int SHL_A = 13;
	localparam int SHR_B = 7;
	localparam int SHL_C = 17;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	function automatic logic [DRAW_W-1:0] xorshift64(input logic [DRAW_W-1:0] s);
		logic [DRAW_W-1:0] x;
		x = s;
		x = x ^ (x << SHL_A);
		x = x ^ (x >> SHR_B);
		x = x ^ (x << SHL_C);
		return x;
	endfunction

endpackage
`default_nettype wire

/* rtl/rcrb_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcrb_divider
// Restoring remainder unit: 64-bit draw modulo a narrow divisor, one bit per
// cycle.
// ----------------------------------------------------------------------------
module rcrb_divider #(
	parameter int IW = 10
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [rcrb_pkg::DRAW_W-1:0] dividend,
	input  wire logic [IW:0]                 divisor,
	output rcrb_pkg::div_status_t            status,
	output logic [IW-1:0]                    remainder
);

	localparam int NW    = IW + 1;
	localparam int CNT_W = $clog2(rcrb_pkg::DRAW_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(rcrb_pkg::DRAW_W - 1);

	logic [rcrb_pkg::DRAW_W-1:0] dvd_q;
	logic [IW-1:0]               rem_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;

	logic [NW-1:0] trial;
	logic [IW-1:0] rem_next;

	// shift in next dividend bit, subtract when it fits
	assign trial = {rem_q, dvd_q[rcrb_pkg::DRAW_W-1]};
	always_comb begin
		if (trial >= divisor) begin
			rem_next = IW'(trial - divisor);
		end else begin
			rem_next = trial[IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_next;
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign remainder   = rem_q;

`ifndef SYNTHESIS
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (NW'(rem_q) < divisor))
		else $error("remainder not below divisor");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("divider did not start");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !start && cnt_q == CNT_LAST) |=> (done_q && !busy_q))
		else $error("divider did not finish after last bit");
`endif

endmodule
`default_nettype wire

/* rtl/random_cyclic_ring_builder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// random_cyclic_ring_builder
// Builds one random cycle over a table with a Fisher-Yates shuffle, then
// serves successor lookups.
// ----------------------------------------------------------------------------
// Usage:
//  cfg channel: cfg_valid/cfg_ready/cfg_data write ring_length (always ready);
//    write only while the block is idle. Reset value is 1024.
//  s_axis: tuser = action (0 build, 1 lookup), tdata[9:0] = entry_index.
//  m_axis: tdata[9:0] = successor_index, tuser = build_done.
//  Lookup: one transaction per cycle while idle and the output queue has room,
//    result valid after the successor memory read, then the output queue.
//  Build: the input stalls until done; for an effective length n it runs an
//    identity fill of n entries, then n-1 swaps, each a draw, a bit-serial
//    modulo and four permutation memory accesses, then a link pass over the
//    permutation read port.
//  A four-entry output queue decouples the sides: lookups keep entering while
//    results wait, and input stops when the queue could overflow.
//  Reset clears control state and the generator; both tables are undefined
//    until a build writes them, so look up only entries a build has covered.
// ----------------------------------------------------------------------------
module random_cyclic_ring_builder #(
	parameter int MAX_ENTRIES = rcrb_pkg::MAX_ENTRIES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration: ring_length
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [rcrb_pkg::LEN_W-1:0]   cfg_data,
	// input stream
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [rcrb_pkg::TDATA_W-1:0] s_axis_tdata,   // [9:0] entry_index
	input  wire logic                         s_axis_tuser,   // [0] action
	// result stream
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	output logic [rcrb_pkg::TDATA_W-1:0]      m_axis_tdata,   // [9:0] successor_index
	output logic                              m_axis_tuser    // [0] build_done
);

	localparam int IW = $clog2(MAX_ENTRIES);          // table address width
	localparam int NW = IW + 1;                        // holds n up to MAX_ENTRIES
	localparam int CW = (NW > rcrb_pkg::LEN_W) ? NW : rcrb_pkg::LEN_W;
	localparam int OBUF_DEPTH = 4;
	localparam int OP_W = $clog2(OBUF_DEPTH);
	localparam int OC_W = $clog2(OBUF_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_FILL, ST_SEED, ST_DRAW, ST_DIV,
		ST_RD_I, ST_RD_J, ST_WR_I, ST_WR_J, ST_LINK, ST_WRAP, ST_FIN
	} state_t;

	typedef struct packed {
		logic [rcrb_pkg::IDX_W-1:0] succ;
		logic                       done;
	} result_t;

	// ---------------- config ----------------
	logic [rcrb_pkg::LEN_W-1:0] ring_length_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_length_q <= rcrb_pkg::LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ring_length_q <= cfg_data;
		end
	end

	// effective length, clamped to 2 .. MAX_ENTRIES
	logic [CW-1:0] len_x;
	logic [NW-1:0] n_sat;

	assign len_x = CW'(ring_length_q);
	always_comb begin
		if (len_x < CW'(rcrb_pkg::MIN_RING)) begin
			n_sat = NW'(rcrb_pkg::MIN_RING);
		end else if (len_x > CW'(MAX_ENTRIES)) begin
			n_sat = NW'(MAX_ENTRIES);
		end else begin
			n_sat = NW'(len_x);
		end
	end

	// ---------------- sequencer registers ----------------
	state_t                      state_q;
	logic [NW-1:0]               n_q;
	logic [NW-1:0]               k_q;      // fill / link counter
	logic [IW-1:0]               i_q;      // shuffle position, high to low
	logic [IW-1:0]               j_q;      // pick
	logic [rcrb_pkg::DRAW_W-1:0] gen_q;    // xorshift state
	logic [IW-1:0]               pi_q;     // perm[i] held for the swap
	logic [IW-1:0]               first_q;  // perm[0], closes the ring
	logic [IW-1:0]               prev_q;   // previous entry in link pass

	logic in_acc;
	logic is_build;
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign is_build = (s_axis_tuser == rcrb_pkg::ACT_BUILD);

	// ---------------- modulo unit ----------------
	logic                        div_start;
	logic [rcrb_pkg::DRAW_W-1:0] draw;
	logic [NW-1:0]               divisor;
	rcrb_pkg::div_status_t       div_status;
	logic [IW-1:0]               div_rem;

	assign draw      = rcrb_pkg::xorshift64(gen_q);
	assign div_start = (state_q == ST_DRAW);
	assign divisor   = NW'(i_q) + NW'(1);

	rcrb_divider #(
		.IW(IW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (draw),
		.divisor  (divisor),
		.status   (div_status),
		.remainder(div_rem)
	);

	// ---------------- memories ----------------
	logic [IW-1:0] perm_mem [MAX_ENTRIES];
	logic [IW-1:0] succ_mem [MAX_ENTRIES];

	logic          perm_we;
	logic [IW-1:0] perm_waddr;
	logic [IW-1:0] perm_wdata;
	logic [IW-1:0] perm_raddr;
	logic [IW-1:0] perm_rdata_q;

	logic          succ_we;
	logic [IW-1:0] succ_waddr;
	logic [IW-1:0] succ_wdata;
	logic [IW-1:0] succ_raddr;
	logic [IW-1:0] succ_rdata_q;

	always_ff @(posedge clk) begin
		if (perm_we) begin
			perm_mem[perm_waddr] <= perm_wdata;
		end
		perm_rdata_q <= perm_mem[perm_raddr];
	end

	always_ff @(posedge clk) begin
		if (succ_we) begin
			succ_mem[succ_waddr] <= succ_wdata;
		end
		succ_rdata_q <= succ_mem[succ_raddr];
	end

	// lookup address straight from the input bus
	assign succ_raddr = IW'(s_axis_tdata[rcrb_pkg::IDX_W-1:0]);

	// memory port control per sequencer step
	always_comb begin
		perm_we    = 1'b0;
		perm_waddr = i_q;
		perm_wdata = perm_rdata_q;
		perm_raddr = i_q;
		succ_we    = 1'b0;
		succ_waddr = prev_q;
		succ_wdata = perm_rdata_q;
		unique case (state_q)
			ST_FILL: begin
				perm_we    = 1'b1;
				perm_waddr = k_q[IW-1:0];
				perm_wdata = k_q[IW-1:0];
			end
			ST_RD_I: begin
				perm_raddr = i_q;
			end
			ST_RD_J: begin
				perm_raddr = j_q;
			end
			ST_WR_I: begin
				// read data is perm[j]
				perm_we    = 1'b1;
				perm_waddr = i_q;
				perm_wdata = perm_rdata_q;
			end
			ST_WR_J: begin
				perm_we    = 1'b1;
				perm_waddr = j_q;
				perm_wdata = pi_q;
			end
			ST_LINK: begin
				// read perm[k]; data in hand is perm[k-1]
				perm_raddr = k_q[IW-1:0];
				if (k_q > NW'(1)) begin
					succ_we = 1'b1;
				end
			end
			ST_WRAP: begin
				succ_we    = 1'b1;
				succ_wdata = first_q;
			end
			default: begin
			end
		endcase
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			k_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			gen_q   <= '0;
			pi_q    <= '0;
			first_q <= '0;
			prev_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && is_build) begin
						n_q     <= n_sat;
						k_q     <= '0;
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					if (k_q == n_q - NW'(1)) begin
						state_q <= ST_SEED;
					end else begin
						k_q <= k_q + NW'(1);
					end
				end
				ST_SEED: begin
					gen_q   <= rcrb_pkg::SEED_CONST ^ rcrb_pkg::DRAW_W'(n_q);
					i_q     <= IW'(n_q - NW'(1));
					state_q <= ST_DRAW;
				end
				ST_DRAW: begin
					gen_q   <= draw;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_status.done) begin
						j_q     <= div_rem;
						state_q <= ST_RD_I;
					end
				end
				ST_RD_I: begin
					state_q <= ST_RD_J;
				end
				ST_RD_J: begin
					pi_q    <= perm_rdata_q;
					state_q <= ST_WR_I;
				end
				ST_WR_I: begin
					state_q <= ST_WR_J;
				end
				ST_WR_J: begin
					if (i_q == IW'(1)) begin
						k_q     <= '0;
						state_q <= ST_LINK;
					end else begin
						i_q     <= i_q - IW'(1);
						state_q <= ST_DRAW;
					end
				end
				ST_LINK: begin
					if (k_q == NW'(1)) begin
						first_q <= perm_rdata_q;
					end
					if (k_q != '0) begin
						prev_q <= perm_rdata_q;
					end
					if (k_q == n_q) begin
						state_q <= ST_WRAP;
					end else begin
						k_q <= k_q + NW'(1);
					end
				end
				ST_WRAP: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ---------------- lookup stage ----------------
	logic lk_valid_s1;
	logic lk_oor_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lk_valid_s1 <= 1'b0;
		end else begin
			lk_valid_s1 <= in_acc && !is_build;
		end
	end

	// entries past the table answer zero
	always_ff @(posedge clk) begin
		lk_oor_s1 <= (32'(s_axis_tdata[rcrb_pkg::IDX_W-1:0]) >= 32'(MAX_ENTRIES));
	end

	// ---------------- output queue ----------------
	result_t         obuf_q [OBUF_DEPTH];
	logic [OP_W-1:0] wr_ptr_q;
	logic [OP_W-1:0] rd_ptr_q;
	logic [OC_W-1:0] count_q;

	logic    push;
	logic    pop;
	result_t push_data;

	assign push = lk_valid_s1 || (state_q == ST_FIN);
	assign pop  = m_axis_tvalid && m_axis_tready;

	always_comb begin
		if (state_q == ST_FIN) begin
			push_data.succ = '0;
			push_data.done = 1'b1;
		end else begin
			push_data.succ = lk_oor_s1 ? '0 : rcrb_pkg::IDX_W'(succ_rdata_q);
			push_data.done = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OP_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OP_W'(1);
			end
			count_q <= count_q + OC_W'(push) - OC_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			obuf_q[wr_ptr_q] <= push_data;
		end
	end

	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tdata  = rcrb_pkg::TDATA_W'(obuf_q[rd_ptr_q].succ);
	assign m_axis_tuser  = obuf_q[rd_ptr_q].done;

	// room for the lookup in flight plus this transaction
	assign s_axis_tready = (state_q == ST_IDLE)
		&& ((count_q + OC_W'(lk_valid_s1)) < OC_W'(OBUF_DEPTH));

`ifndef SYNTHESIS
	a_obuf_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (count_q < OC_W'(OBUF_DEPTH)))
		else $error("output queue overflow");

	a_pick_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_I) |-> (j_q <= i_q))
		else $error("shuffle pick above position");

	a_build_starts_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && is_build) |=> (state_q == ST_FILL))
		else $error("build transaction did not start fill");

	a_single_push_source: assert property (@(posedge clk) disable iff (!arst_n)
		!(lk_valid_s1 && state_q == ST_FIN))
		else $error("lookup and build result pushed together");

	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_status.busy || div_status.done))
		else $error("waiting on an idle divider");
`endif

endmodule
`default_nettype wire
